// ===== rtl/iat_pkg.sv =====
package iat_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_CHECK   = 3'd2,
    CMD_LIST    = 3'd3,
    CMD_MERGED  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_APPEND,
    S_LIST,
    S_RESULT
  } state_t;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

endpackage

// ===== rtl/iat_if.sv =====
interface iat_in_if #(parameter int unsigned CW = 16);
  logic                          valid;
  logic                          ready;
  logic [iat_pkg::CMD_W-1:0]     command;
  logic [CW-1:0]                 low_bound;
  logic [CW-1:0]                 high_bound;
  modport source (output valid, command, low_bound, high_bound, input ready);
  modport sink   (input valid, command, low_bound, high_bound, output ready);
endinterface

interface iat_out_if #(parameter int unsigned CW = 16);
  logic                          valid;
  logic                          ready;
  logic [iat_pkg::STATUS_W-1:0]  status;
  logic                          available;
  logic                          entry_valid;
  logic [CW-1:0]                 entry_start;
  logic [CW-1:0]                 entry_end;
  logic                          last;
  modport source (output valid, status, available, entry_valid, entry_start, entry_end,
                  last, input ready);
  modport sink   (input valid, status, available, entry_valid, entry_start, entry_end,
                  last, output ready);
endinterface

// ===== rtl/iat_mem.sv =====
module iat_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/interval_allocation_table.sv =====
// Interval allocation table: keeps up to TABLE_DEPTH half-open ranges
// [start, end) sorted by start, then end, in one synchronous memory.
// Input channel (in_): one command per transfer with low and high bounds.
// Output channel (out_): one or more results per command; last marks the
// final result of a command. Commands are handled one at a time.
// Release and check each make one pass over the stored entries, one entry
// per cycle (the memory read is registered, so each entry is read ahead of
// its compare). An allocate adds a second pass that compacts the table and
// writes the new range in sorted order, with an extra step for the insertion
// (a re-read of the displaced entry, or a final append). A plain list emits
// one result per stored entry, one per cycle while the receiver keeps up, and
// a merged list one per group of touching or overlapping entries; each entry
// is read ahead of its use.
// Reset is synchronous and active low; it empties the table (count only),
// no clearing pass is needed. A stalled receiver holds the output register
// and the block simply waits; the next command is taken once the last
// result of the current one has been transferred.
module interval_allocation_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  iat_in_if.sink    in_ch,
  iat_out_if.source out_ch
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = COORD_WIDTH;
  localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

  iat_pkg::state_t state_r, state_nxt;
  logic [iat_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] rd_i_r, rd_i_nxt;   // next index to read
  logic [NW-1:0] wr_n_r, wr_n_nxt;   // compacted write index / insert pos
  logic          pend_r, pend_nxt;   // read data valid for index rd_i_r-1
  logic          avail_r, avail_nxt;
  logic          found_r, found_nxt; // insertion position found
  logic [NW-1:0] pos_r, pos_nxt;
  logic          merge_act_r, merge_act_nxt;
  logic [CW-1:0] cs_r, cs_nxt, ce_r, ce_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    o_status_r, o_status_nxt;
  logic          o_avail_r, o_avail_nxt, o_ev_r, o_ev_nxt, o_last_r, o_last_nxt;
  logic [CW-1:0] o_s_r, o_s_nxt, o_e_r, o_e_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [2*CW-1:0] wr_data, rd_data;
  logic [CW-1:0] m_s, m_e;

  iat_mem #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(2*CW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign m_s = rd_data[2*CW-1:CW];
  assign m_e = rd_data[CW-1:0];

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;

  assign in_ch.ready       = (state_r == iat_pkg::S_IDLE) && !ov_r;
  assign out_ch.valid       = ov_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.available   = o_avail_r;
  assign out_ch.entry_valid = o_ev_r;
  assign out_ch.entry_start = o_s_r;
  assign out_ch.entry_end   = o_e_r;
  assign out_ch.last        = o_last_r;

  logic cont;      // current read entry lies wholly inside the request
  logic sorts_low; // current entry sorts ahead of the new range
  assign cont      = (lo_r <= m_s) && (m_e <= hi_r);
  assign sorts_low = (m_s < lo_r) || ((m_s == lo_r) && (m_e <= hi_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iat_pkg::S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
    cmd_r <= cmd_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    rd_i_r <= rd_i_nxt; wr_n_r <= wr_n_nxt; avail_r <= avail_nxt;
    found_r <= found_nxt; pos_r <= pos_nxt; merge_act_r <= merge_act_nxt;
    cs_r <= cs_nxt; ce_r <= ce_nxt;
    o_status_r <= o_status_nxt; o_avail_r <= o_avail_nxt; o_ev_r <= o_ev_nxt;
    o_last_r <= o_last_nxt; o_s_r <= o_s_nxt; o_e_r <= o_e_nxt;
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; cmd_nxt = cmd_r;
    lo_nxt = lo_r; hi_nxt = hi_r; rd_i_nxt = rd_i_r; wr_n_nxt = wr_n_r;
    pend_nxt = 1'b0; avail_nxt = avail_r; found_nxt = found_r; pos_nxt = pos_r;
    merge_act_nxt = merge_act_r; cs_nxt = cs_r; ce_nxt = ce_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_status_nxt = o_status_r; o_avail_nxt = o_avail_r; o_ev_nxt = o_ev_r;
    o_last_nxt = o_last_r; o_s_nxt = o_s_r; o_e_nxt = o_e_r;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;

    unique case (state_r)
      iat_pkg::S_IDLE: begin
        rd_addr = '0;
        if (in_ch.valid && in_ch.ready) begin
          cmd_nxt = in_ch.command; lo_nxt = in_ch.low_bound; hi_nxt = in_ch.high_bound;
          rd_i_nxt = NW'(1); wr_n_nxt = '0; pend_nxt = (count_r != '0);
          avail_nxt = 1'b1; found_nxt = 1'b0; pos_nxt = count_r;
          merge_act_nxt = 1'b0;
          o_status_nxt = iat_pkg::ST_OK; o_avail_nxt = 1'b0; o_ev_nxt = 1'b0;
          o_last_nxt = 1'b1; o_s_nxt = '0; o_e_nxt = '0;
          if (in_ch.command <= iat_pkg::CMD_CHECK) begin
            if (in_ch.low_bound >= in_ch.high_bound) begin
              o_status_nxt = iat_pkg::ST_INVALID;
              state_nxt = iat_pkg::S_RESULT;
            end else begin
              state_nxt = iat_pkg::S_SCAN;
            end
          end else if ((in_ch.command == iat_pkg::CMD_LIST ||
                        in_ch.command == iat_pkg::CMD_MERGED) && count_r != '0) begin
            state_nxt = iat_pkg::S_LIST;
          end else begin
            state_nxt = iat_pkg::S_RESULT;
          end
        end
      end

      iat_pkg::S_SCAN: begin
        // Entry rd_i_r-1 is on the read port when pend_r is set.
        rd_addr = rd_i_r[AW-1:0];
        if (pend_r) begin
          if (cmd_r == iat_pkg::CMD_CHECK) begin
            if ((lo_r < m_e) && (m_s < hi_r)) avail_nxt = 1'b0;
          end else if (!cont) begin
            if (cmd_r == iat_pkg::CMD_ALLOC && !found_r && !sorts_low) begin
              found_nxt = 1'b1; pos_nxt = wr_n_r;
            end
            // Allocate compaction is deferred to after the full check.
            if (cmd_r == iat_pkg::CMD_RELEASE) begin
              wr_en = 1'b1; wr_addr = wr_n_r[AW-1:0]; wr_data = {m_s, m_e};
            end
            wr_n_nxt = wr_n_r + NW'(1);
          end
        end
        if (rd_i_r < count_r) begin
          rd_i_nxt = rd_i_r + NW'(1); pend_nxt = 1'b1;
        end else begin
          // Scan complete (the last entry was handled this cycle if pending).
          if (cmd_r == iat_pkg::CMD_CHECK) begin
            o_avail_nxt = avail_nxt;
            state_nxt = iat_pkg::S_RESULT;
          end else if (cmd_r == iat_pkg::CMD_RELEASE) begin
            count_nxt = wr_n_nxt;
            state_nxt = iat_pkg::S_RESULT;
          end else if (wr_n_nxt >= DEPTH_N) begin
            o_status_nxt = iat_pkg::ST_FULL;
            state_nxt = iat_pkg::S_RESULT;
          end else begin
            // Second pass: compact and insert, entry by entry.
            if (!found_nxt) pos_nxt = wr_n_nxt;
            rd_addr = '0; rd_i_nxt = NW'(1); pend_nxt = (count_r != '0);
            wr_n_nxt = '0; merge_act_nxt = 1'b0;
            state_nxt = iat_pkg::S_INSERT;
          end
        end
      end

      iat_pkg::S_INSERT: begin
        // merge_act_r: new range already written, wr_n_r counts it.
        rd_addr = rd_i_r[AW-1:0];
        if (pend_r) begin
          if (!cont) begin
            if (!merge_act_r && wr_n_r == pos_r) begin
              wr_en = 1'b1; wr_addr = wr_n_r[AW-1:0]; wr_data = {lo_r, hi_r};
              merge_act_nxt = 1'b1;
              // Re-read this entry; the read returns the value before the write.
              wr_n_nxt = wr_n_r + NW'(1);
              rd_addr = rd_i_r[AW-1:0] - AW'(1);
              pend_nxt = 1'b1;
            end else begin
              wr_en = 1'b1; wr_addr = wr_n_r[AW-1:0]; wr_data = {m_s, m_e};
              wr_n_nxt = wr_n_r + NW'(1);
            end
          end
        end
        if (!(pend_r && !cont && !merge_act_r && wr_n_r == pos_r)) begin
          if (rd_i_r < count_r) begin
            rd_i_nxt = rd_i_r + NW'(1); pend_nxt = 1'b1;
          end else begin
            if (!merge_act_nxt) begin
              // The port may be busy with the last kept entry this cycle.
              state_nxt = iat_pkg::S_APPEND;
            end else begin
              count_nxt = wr_n_nxt;
              state_nxt = iat_pkg::S_RESULT;
            end
          end
        end
      end

      iat_pkg::S_APPEND: begin
        // The new range sorts after every kept entry and goes at the end.
        wr_en = 1'b1; wr_addr = wr_n_r[AW-1:0]; wr_data = {lo_r, hi_r};
        count_nxt = wr_n_r + NW'(1);
        state_nxt = iat_pkg::S_RESULT;
      end

      iat_pkg::S_LIST: begin
        // Keep entry rd_i_r-1 on the read port until it has been used.
        rd_addr = rd_i_r[AW-1:0] - AW'(1);
        pend_nxt = pend_r;
        if (pend_r && out_free) begin
          pend_nxt = 1'b0;
          if (cmd_r == iat_pkg::CMD_LIST) begin
            ov_nxt = 1'b1; o_ev_nxt = 1'b1; o_s_nxt = m_s; o_e_nxt = m_e;
            o_last_nxt = (rd_i_r == count_r);
          end else if (!merge_act_r) begin
            merge_act_nxt = 1'b1; cs_nxt = m_s; ce_nxt = m_e;
          end else if (ce_r >= m_s) begin
            if (m_e > ce_r) ce_nxt = m_e;
          end else begin
            ov_nxt = 1'b1; o_ev_nxt = 1'b1; o_s_nxt = cs_r; o_e_nxt = ce_r;
            o_last_nxt = 1'b0; cs_nxt = m_s; ce_nxt = m_e;
          end
          if (rd_i_r < count_r) begin
            rd_addr = rd_i_r[AW-1:0];
            rd_i_nxt = rd_i_r + NW'(1); pend_nxt = 1'b1;
          end else if (cmd_r == iat_pkg::CMD_LIST) begin
            state_nxt = iat_pkg::S_IDLE;
          end else begin
            state_nxt = iat_pkg::S_RESULT;
            o_ev_nxt = 1'b1; o_last_nxt = 1'b1;
            o_s_nxt = cs_nxt; o_e_nxt = ce_nxt;
            // A closed group emitted now sends the final one from S_RESULT instead.
            if (ov_nxt) begin
              merge_act_nxt = 1'b1;
              o_s_nxt = cs_r; o_e_nxt = ce_r; o_last_nxt = 1'b0;
            end else begin
              merge_act_nxt = 1'b0;
            end
          end
        end else if (!pend_r) begin
          pend_nxt = 1'b1;
        end
      end

      iat_pkg::S_RESULT: begin
        // merge_act_r set here means a final merged range is still owed.
        if (out_free) begin
          ov_nxt = 1'b1;
          if (cmd_r == iat_pkg::CMD_MERGED && merge_act_r) begin
            o_ev_nxt = 1'b1; o_s_nxt = cs_r; o_e_nxt = ce_r; o_last_nxt = 1'b1;
            merge_act_nxt = 1'b0;
            ov_nxt = 1'b1;
            state_nxt = iat_pkg::S_IDLE;
          end else begin
            state_nxt = iat_pkg::S_IDLE;
          end
        end
      end

      default: state_nxt = iat_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_N) else $error("table count above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready with result pending");
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iat_pkg::S_LIST) |=> $stable(count_r)) else $error("count moved in list");
`endif

endmodule

// ===== bench/interval_allocation_table_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the interval allocation table.
// A directed table opens the run (empty-table lists, invalid ranges, a full
// table, contained-range drops, touching merges); a random phase follows,
// in which allocates are the commonest command, mostly in a narrow window so that ranges overlap and nest.
module interval_allocation_table_tb;

  localparam int DEPTH     = 16;
  localparam int CW        = 16;
  localparam int LIMIT_CYC = 400000;
  localparam int N_RANDOM  = 124;

  typedef struct packed {
    logic [1:0]    status;
    logic          available;
    logic          entry_valid;
    logic [CW-1:0] entry_start;
    logic [CW-1:0] entry_end;
    logic          last;
  } outcome_t;

  typedef struct {
    logic [2:0]    command;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    bit            typed;      // expected result typed in the row
    outcome_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iat_in_if  #(.CW(CW)) in_ch ();
  iat_out_if #(.CW(CW)) out_ch ();

  interval_allocation_table #(.TABLE_DEPTH(DEPTH), .COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table, updated as each command is transferred in.
  logic [CW-1:0] shadow_start [DEPTH];
  logic [CW-1:0] shadow_end   [DEPTH];
  int            shadow_count;

  outcome_t pending_results [$];
  int       fail_count;
  int       result_count;
  int       cycle_count;
  int       list_rows;
  bit       in_idle_ok  = 1'b1;
  bit       out_idle_ok = 1'b1;
  bit       long_hold;
  row_t     directed [$];

  task automatic report_mismatch(input string what, input outcome_t got, input outcome_t want);
    fail_count++;
    $display("MISMATCH %0s: got %p want %p", what, got, want);
  endtask

  function automatic outcome_t make_res(logic [1:0] st, logic av, logic ev,
                                        logic [CW-1:0] s, logic [CW-1:0] e, logic lst);
    outcome_t r;
    r.status = st; r.available = av; r.entry_valid = ev;
    r.entry_start = s; r.entry_end = e; r.last = lst;
    return r;
  endfunction

  // Appends one expected result to the queue.
  function automatic void expect_result(outcome_t r);
    pending_results = {pending_results, r};
  endfunction

  // Compacts out every stored range lying wholly inside [lo, hi).
  function automatic void drop_enclosed(logic [CW-1:0] lo, logic [CW-1:0] hi);
    int n;
    n = 0;
    for (int i = 0; i < shadow_count; i++)
      if (!(lo <= shadow_start[i] && shadow_end[i] <= hi)) begin
        shadow_start[n] = shadow_start[i];
        shadow_end[n]   = shadow_end[i];
        n++;
      end
    shadow_count = n;
  endfunction

  // Works out the results one command causes and advances the shadow table.
  function automatic void predict_table(logic [2:0] cmd, logic [CW-1:0] lo, logic [CW-1:0] hi);
    int kept, pos;
    logic avail;
    logic [CW-1:0] cs, ce;
    if (cmd <= iat_pkg::CMD_CHECK) begin
      if (lo >= hi) begin
        expect_result(make_res(iat_pkg::ST_INVALID, 0, 0, 0, 0, 1));
        return;
      end
      if (cmd == iat_pkg::CMD_ALLOC) begin
        kept = 0;
        for (int i = 0; i < shadow_count; i++)
          if (!(lo <= shadow_start[i] && shadow_end[i] <= hi)) kept++;
        if (kept >= DEPTH) begin
          expect_result(make_res(iat_pkg::ST_FULL, 0, 0, 0, 0, 1));
          return;
        end
        drop_enclosed(lo, hi);
        pos = 0;
        while (pos < shadow_count && (shadow_start[pos] < lo ||
               (shadow_start[pos] == lo && shadow_end[pos] <= hi)))
          pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_start[i] = shadow_start[i-1];
          shadow_end[i]   = shadow_end[i-1];
        end
        shadow_start[pos] = lo;
        shadow_end[pos]   = hi;
        shadow_count++;
        expect_result(make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
      end else if (cmd == iat_pkg::CMD_RELEASE) begin
        drop_enclosed(lo, hi);
        expect_result(make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
      end else begin
        avail = 1'b1;
        for (int i = 0; i < shadow_count; i++)
          if (lo < shadow_end[i] && shadow_start[i] < hi) avail = 1'b0;
        expect_result(make_res(iat_pkg::ST_OK, avail, 0, 0, 0, 1));
      end
    end else if (cmd == iat_pkg::CMD_LIST || cmd == iat_pkg::CMD_MERGED) begin
      if (shadow_count == 0) begin
        expect_result(make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
      end else if (cmd == iat_pkg::CMD_LIST) begin
        for (int i = 0; i < shadow_count; i++)
          expect_result(make_res(iat_pkg::ST_OK, 0, 1, shadow_start[i], shadow_end[i],
                                 i == shadow_count - 1));
      end else begin
        cs = shadow_start[0];
        ce = shadow_end[0];
        for (int i = 1; i < shadow_count; i++) begin
          if (ce >= shadow_start[i]) begin
            if (shadow_end[i] > ce) ce = shadow_end[i];
          end else begin
            expect_result(make_res(iat_pkg::ST_OK, 0, 1, cs, ce, 0));
            cs = shadow_start[i];
            ce = shadow_end[i];
          end
        end
        expect_result(make_res(iat_pkg::ST_OK, 0, 1, cs, ce, 1));
      end
    end else begin
      // Codes above the merged list do nothing but answer once.
      expect_result(make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    end
  endfunction

  // Sends one command and waits for its transfer; the prediction is made at
  // the accepting edge so that the shadow table follows the block's order.
  // Valid stays high after a transfer until the next command or an idle gap.
  task automatic send_command(input logic [2:0] cmd, input logic [CW-1:0] lo,
                              input logic [CW-1:0] hi, input bit typed, input outcome_t want);
    int gap;
    if (in_idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.low_bound  <= lo;
    in_ch.high_bound <= hi;
    do @(posedge clk); while (!in_ch.ready);
    predict_table(cmd, lo, hi);
    // A typed row must agree with the predictor before it is trusted.
    if (typed && pending_results[$] != want)
      report_mismatch("directed row", pending_results[$], want);
  endtask

  task automatic add_row(input logic [2:0] cmd, input int lo, input int hi);
    row_t r;
    r.command = cmd; r.lo = CW'(lo); r.hi = CW'(hi); r.typed = 1'b0; r.want = '0;
    directed = {directed, r};
  endtask

  task automatic add_typed(input logic [2:0] cmd, input int lo, input int hi, input outcome_t w);
    row_t r;
    r.command = cmd; r.lo = CW'(lo); r.hi = CW'(hi); r.typed = 1'b1; r.want = w;
    directed = {directed, r};
  endtask

  // Result checker: compares each transfer out with the oldest expectation.
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = make_res(out_ch.status, out_ch.available, out_ch.entry_valid,
                     out_ch.entry_start, out_ch.entry_end, out_ch.last);
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)           report_mismatch("status", got, want);
        if (got.available !== want.available)     report_mismatch("available", got, want);
        if (got.entry_valid !== want.entry_valid) report_mismatch("entry_valid", got, want);
        if (got.entry_start !== want.entry_start) report_mismatch("entry_start", got, want);
        if (got.entry_end !== want.entry_end)     report_mismatch("entry_end", got, want);
        if (got.last !== want.last)               report_mismatch("last", got, want);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (out_idle_ok && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYC) begin
      $display("Timed out with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [2:0]    cmd;
    logic [CW-1:0] lo, hi;
    int            pick, wait_cyc;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= '0;
    in_ch.low_bound  <= '0;
    in_ch.high_bound <= '0;
    shadow_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    add_typed(iat_pkg::CMD_LIST,    0, 0,         make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_MERGED,  65535, 65535, make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_CHECK,   0, 65535,     make_res(iat_pkg::ST_OK, 1, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_ALLOC,   5, 5,         make_res(iat_pkg::ST_INVALID, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_RELEASE, 65535, 0,     make_res(iat_pkg::ST_INVALID, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_CHECK,   9, 3,         make_res(iat_pkg::ST_INVALID, 0, 0, 0, 0, 1));
    add_typed(3'd5,                 1, 2,         make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_typed(3'd7,                 65535, 0,     make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_ALLOC,   0, 65535,     make_res(iat_pkg::ST_OK, 0, 0, 0, 0, 1));
    add_typed(iat_pkg::CMD_LIST,    0, 0,         make_res(iat_pkg::ST_OK, 0, 1, 0, 65535, 1));
    add_row(iat_pkg::CMD_ALLOC, 10, 20);          // nested inside the full range
    add_row(iat_pkg::CMD_ALLOC, 20, 30);          // touches the previous one
    add_row(iat_pkg::CMD_ALLOC, 40, 50);
    add_row(iat_pkg::CMD_MERGED, 0, 0);
    add_row(iat_pkg::CMD_RELEASE, 0, 65535);      // drops everything
    for (int i = 0; i < 16; i++) add_row(iat_pkg::CMD_ALLOC, 100 + 2*i, 101 + 2*i);
    add_typed(iat_pkg::CMD_ALLOC, 7, 8,           make_res(iat_pkg::ST_FULL, 0, 0, 0, 0, 1));
    add_row(iat_pkg::CMD_ALLOC, 100, 104);        // replaces two, so it fits
    add_row(iat_pkg::CMD_LIST, 0, 0);
    add_row(iat_pkg::CMD_CHECK, 101, 102);
    add_row(iat_pkg::CMD_MERGED, 0, 0);
    foreach (directed[i])
      send_command(directed[i].command, directed[i].lo, directed[i].hi,
                   directed[i].typed, directed[i].want);

    // Random phase: clustered coordinates, with occasional full-range values.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 40) long_hold = 1'b1;     // receiver backs up; sender waits on ready
      if (n >= 100) begin
        in_idle_ok  = 1'b0;
        out_idle_ok = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = iat_pkg::CMD_ALLOC;
      else if (pick < 60) cmd = iat_pkg::CMD_RELEASE;
      else if (pick < 75) cmd = iat_pkg::CMD_CHECK;
      else if (pick < 85) cmd = iat_pkg::CMD_LIST;
      else if (pick < 96) cmd = iat_pkg::CMD_MERGED;
      else                cmd = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) begin
        lo = CW'($urandom_range(0, 65535));
        hi = CW'($urandom_range(0, 65535));
      end else begin
        lo = CW'($urandom_range(0, 200));
        hi = lo + CW'($urandom_range(0, 40)) - CW'(($urandom_range(0, 15) == 0) ? 1 : 0);
      end
      if (pick >= 56 && pick < 60) begin
        lo = '0; hi = 16'hFFFF;          // clear out to keep the table moving
      end
      send_command(cmd, lo, hi, 1'b0, '0);
      if (cmd == iat_pkg::CMD_LIST || cmd == iat_pkg::CMD_MERGED) list_rows++;
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    wait_cyc = 0;
    while (wait_cyc < 60) begin
      @(posedge clk);
      wait_cyc++;
    end

    $display("Covered %0d commands (%0d random lists), %0d results checked.",
             directed.size() + N_RANDOM, list_rows, result_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
